// ===== src/scba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package scba_pkg;

   // default sizing of the pool
   localparam int BLOCKS_PER_CLASS_DEF = 16;
   localparam int MAX_CHUNK_BYTES_DEF  = 4096;

   // payload field widths
   localparam int KIND_W    = 2;
   localparam int LEN_W     = 16;
   localparam int CLASS_W   = 4;
   localparam int SLOT_IN_W = 4;
   localparam int STATUS_W  = 3;
   localparam int CHUNK_W   = 13;

   // class number before masking (up to 16) and its power of two (up to 65536)
   localparam int LOG_W = 5;
   localparam int POW_W = 17;

   // request kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_ALLOC   = 2'd0,
      KIND_RELEASE = 2'd1,
      KIND_RESIZE  = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_ZERO    = 3'd1,
      ST_LARGE   = 3'd2,
      ST_FULL    = 3'd3,
      ST_FREE    = 3'd4,
      ST_REFUSED = 3'd5
   } status_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;

endpackage

`default_nettype wire

// ===== src/scba_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// request channel
interface scba_req_if;
   import scba_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [KIND_W-1:0]    kind;
   logic [LEN_W-1:0]     length_bytes;
   logic [LEN_W-1:0]     aligned_bytes;
   logic [CLASS_W-1:0]   class_in;
   logic [SLOT_IN_W-1:0] slot_in;

   modport source (output valid, kind, length_bytes, aligned_bytes, class_in, slot_in,
                   input ready);
   modport sink   (input valid, kind, length_bytes, aligned_bytes, class_in, slot_in,
                   output ready);
endinterface

// response channel
interface scba_rsp_if;
   import scba_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 granted;
   logic [STATUS_W-1:0]  status;
   logic [CLASS_W-1:0]   class_out;
   logic [SLOT_IN_W-1:0] slot_out;
   logic [CHUNK_W-1:0]   chunk_bytes;

   modport source (output valid, granted, status, class_out, slot_out, chunk_bytes,
                   input ready);
   modport sink   (input valid, granted, status, class_out, slot_out, chunk_bytes,
                   output ready);
endinterface

`default_nettype wire

// ===== src/scba_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module scba_ctrl import scba_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output cmd_type      cmd
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      exec_go;

   // handshake decode
   assign req_ready = (state_ff == S_IDLE) && !reset;
   assign exec_go   = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign cmd.load  = req_valid && req_ready;
   assign cmd.exec  = exec_go;
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.load) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (exec_go) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output register occupancy
   always_comb begin
      priority if (exec_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/scba_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module scba_datapath import scba_pkg::*; #(
   parameter int BLOCKS_PER_CLASS = BLOCKS_PER_CLASS_DEF,
   parameter int MAX_CHUNK_BYTES  = MAX_CHUNK_BYTES_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cmd_type              cmd,
   input  wire logic [KIND_W-1:0]    req_kind,
   input  wire logic [LEN_W-1:0]     req_length_bytes,
   input  wire logic [LEN_W-1:0]     req_aligned_bytes,
   input  wire logic [CLASS_W-1:0]   req_class_in,
   input  wire logic [SLOT_IN_W-1:0] req_slot_in,
   output logic                      rsp_granted,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [CLASS_W-1:0]        rsp_class_out,
   output logic [SLOT_IN_W-1:0]      rsp_slot_out,
   output logic [CHUNK_W-1:0]        rsp_chunk_bytes
);

   localparam int TOP_CLASS   = $clog2(MAX_CHUNK_BYTES + 1) - 1;
   localparam int NUM_CLASSES = TOP_CLASS + 1;
   localparam int CLS_W       = $clog2(NUM_CLASSES);
   localparam int SLOT_W      = (BLOCKS_PER_CLASS > 1) ? $clog2(BLOCKS_PER_CLASS) : 1;
   localparam logic [POW_W-1:0] MAX_BYTES = POW_W'(MAX_CHUNK_BYTES);
   localparam logic [LOG_W-1:0] TOP_CLS   = LOG_W'(TOP_CLASS);
   localparam logic [6:0]       BPC       = 7'(BLOCKS_PER_CLASS);

   // smallest k with 2^k >= value
   function automatic logic [LOG_W-1:0] ceil_log2(input logic [LEN_W-1:0] value);
      logic [LEN_W-1:0] v;
      logic [LOG_W-1:0] k;
      v = value - LEN_W'(1);
      k = '0;
      if (value > LEN_W'(1)) begin
         for (int b = 0; b < LEN_W; b++) begin
            if (v[b]) k = LOG_W'(b + 1);
         end
      end
      return k;
   endfunction

   // request decode at transfer
   kind_type          kind_in, kind_ff;
   logic              zero_in, zero_ff;
   logic              large_in, large_ff;
   logic              range_in, range_ff;
   logic              fit_in, fit_ff;
   logic [LOG_W-1:0]  k_in;
   logic [LOG_W-1:0]  cls_in, cls_ff;
   logic [SLOT_IN_W-1:0] slot_ff;

   always_comb begin
      kind_in  = kind_type'(req_kind);
      zero_in  = (req_length_bytes == '0) || (req_aligned_bytes == '0);
      k_in     = ceil_log2(req_aligned_bytes);
      large_in = ({1'b0, req_aligned_bytes} > MAX_BYTES) || (k_in > TOP_CLS);
      range_in = ({1'b0, req_class_in} <= TOP_CLS) && ({3'b000, req_slot_in} < BPC);
      fit_in   = ({1'b0, req_length_bytes} <= (POW_W'(1) << req_class_in));
      cls_in   = (kind_in == KIND_ALLOC) ? k_in : {1'b0, req_class_in};
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= kind_in;
         zero_ff  <= zero_in;
         large_ff <= large_in;
         range_ff <= range_in;
         fit_ff   <= fit_in;
         cls_ff   <= cls_in;
         slot_ff  <= req_slot_in;
      end
   end

   // busy bitmap, one word per class
   logic [BLOCKS_PER_CLASS-1:0] busy_ff [NUM_CLASSES];

   logic                        row_ok;
   logic [CLS_W+LOG_W-1:0]      cls_ext;
   logic [CLS_W-1:0]            row_idx;
   logic [BLOCKS_PER_CLASS-1:0] word;
   logic [SLOT_W+SLOT_IN_W-1:0] slot_ext;
   logic [SLOT_W-1:0]           slot_idx;
   logic                        slot_busy;
   logic                        found;
   logic [SLOT_W-1:0]           free_idx;
   logic [SLOT_W+SLOT_IN_W-1:0] free_ext;
   logic [POW_W-1:0]            pow;

   // row read and slot lookup
   always_comb begin
      row_ok    = (kind_ff == KIND_ALLOC) ? (!zero_ff && !large_ff) : range_ff;
      cls_ext   = {CLS_W'(0), cls_ff};
      row_idx   = cls_ext[CLS_W-1:0];
      word      = row_ok ? busy_ff[row_idx] : '0;
      slot_ext  = {SLOT_W'(0), slot_ff};
      slot_idx  = slot_ext[SLOT_W-1:0];
      slot_busy = range_ff ? word[slot_idx] : 1'b0;
      pow       = POW_W'(1) << cls_ff;
   end

   // lowest free slot
   always_comb begin
      found    = 1'b0;
      free_idx = '0;
      for (int i = BLOCKS_PER_CLASS - 1; i >= 0; i--) begin
         if (!word[i]) begin
            found    = 1'b1;
            free_idx = SLOT_W'(i);
         end
      end
      free_ext = {SLOT_IN_W'(0), free_idx};
   end

   // result and row update
   logic                        granted_in, granted_ff;
   status_type                  status_in, status_ff;
   logic [CLASS_W-1:0]          class_out_in, class_out_ff;
   logic [SLOT_IN_W-1:0]        slot_out_in, slot_out_ff;
   logic [CHUNK_W-1:0]          chunk_in, chunk_ff;
   logic [BLOCKS_PER_CLASS-1:0] word_in;
   logic                        write_en;

   always_comb begin
      granted_in   = 1'b0;
      status_in    = ST_OK;
      class_out_in = '0;
      slot_out_in  = '0;
      chunk_in     = '0;
      word_in      = word;
      write_en     = 1'b0;
      unique case (kind_ff)
         KIND_ALLOC: begin
            priority if (zero_ff) begin
               status_in = ST_ZERO;
            end else if (large_ff) begin
               status_in = ST_LARGE;
            end else if (!found) begin
               status_in = ST_FULL;
            end else begin
               granted_in        = 1'b1;
               class_out_in      = cls_ff[CLASS_W-1:0];
               slot_out_in       = free_ext[SLOT_IN_W-1:0];
               chunk_in          = pow[CHUNK_W-1:0];
               word_in[free_idx] = 1'b1;
               write_en          = 1'b1;
            end
         end
         KIND_RELEASE: begin
            if (slot_busy) begin
               word_in[slot_idx] = 1'b0;
               write_en          = 1'b1;
            end else begin
               status_in = ST_FREE;
            end
         end
         KIND_RESIZE: begin
            if (slot_busy && fit_ff) begin
               granted_in   = 1'b1;
               class_out_in = cls_ff[CLASS_W-1:0];
               slot_out_in  = slot_ff;
               chunk_in     = pow[CHUNK_W-1:0];
            end else begin
               status_in = ST_REFUSED;
            end
         end
         KIND_NONE: begin
            status_in = ST_OK;
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   // bitmap write back
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '{default: '0};
      end else if (cmd.exec && write_en) begin
         busy_ff[row_idx] <= word_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         granted_ff   <= granted_in;
         status_ff    <= status_in;
         class_out_ff <= class_out_in;
         slot_out_ff  <= slot_out_in;
         chunk_ff     <= chunk_in;
      end
   end

   assign rsp_granted     = granted_ff;
   assign rsp_status      = status_ff;
   assign rsp_class_out   = class_out_ff;
   assign rsp_slot_out    = slot_out_ff;
   assign rsp_chunk_bytes = chunk_ff;

endmodule

`default_nettype wire

// ===== src/size_class_block_allocator_core.sv =====
// a request is registered at transfer and executed once the output register is free or read
// each request finishes its read-modify-write of one class word before the next is taken
// a new request is taken while the previous response still waits in the output register
// reset: synchronous, active high; all blocks free, no response pending
`timescale 1ns / 1ps
`default_nettype none

module size_class_block_allocator_core import scba_pkg::*; #(
   parameter int BLOCKS_PER_CLASS = BLOCKS_PER_CLASS_DEF,
   parameter int MAX_CHUNK_BYTES  = MAX_CHUNK_BYTES_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   scba_req_if.sink  req_ch,
   scba_rsp_if.source rsp_ch
);

   cmd_type cmd;
   logic    req_ready;
   logic    rsp_valid;

   // sequencing
   scba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   // bitmap and result path
   scba_datapath #(
      .BLOCKS_PER_CLASS (BLOCKS_PER_CLASS),
      .MAX_CHUNK_BYTES  (MAX_CHUNK_BYTES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_kind          (req_ch.kind),
      .req_length_bytes  (req_ch.length_bytes),
      .req_aligned_bytes (req_ch.aligned_bytes),
      .req_class_in      (req_ch.class_in),
      .req_slot_in       (req_ch.slot_in),
      .rsp_granted       (rsp_ch.granted),
      .rsp_status        (rsp_ch.status),
      .rsp_class_out     (rsp_ch.class_out),
      .rsp_slot_out      (rsp_ch.slot_out),
      .rsp_chunk_bytes   (rsp_ch.chunk_bytes)
   );

   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid;

endmodule

`default_nettype wire

// ===== src/scba_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module scba_checker import scba_pkg::*; (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic                 rsp_granted,
   input wire logic [STATUS_W-1:0]  rsp_status,
   input wire logic [CLASS_W-1:0]   rsp_class_out,
   input wire logic [SLOT_IN_W-1:0] rsp_slot_out,
   input wire logic [CHUNK_W-1:0]   rsp_chunk_bytes
);

   // a transfer closes the request side for the next cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request side open right after a transfer");

   // a grant always reports ok
   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_granted |-> rsp_status == ST_OK)
      else $error("grant with non-ok status");

   // no grant means no block description
   a_refusal_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_granted |->
         rsp_class_out == '0 && rsp_slot_out == '0 && rsp_chunk_bytes == '0)
      else $error("refused response carries block fields");

   // a granted block size is a single power of two or masked away
   a_chunk_pow2: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_granted |-> $onehot0(rsp_chunk_bytes))
      else $error("granted chunk size not a power of two");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_granted) && $stable(rsp_status)
         && $stable(rsp_class_out) && $stable(rsp_slot_out) && $stable(rsp_chunk_bytes))
      else $error("stalled response changed");

endmodule

bind size_class_block_allocator_core scba_checker u_scba_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_granted     (rsp_ch.granted),
   .rsp_status      (rsp_ch.status),
   .rsp_class_out   (rsp_ch.class_out),
   .rsp_slot_out    (rsp_ch.slot_out),
   .rsp_chunk_bytes (rsp_ch.chunk_bytes)
);

`default_nettype wire
